/* rtl/chbd_pkg.sv */
// ============================================================================
// chbd_pkg: shared types and constants for the chunked body decoder
// Holds the item and result structs, the parse phase and status codes, and
// the character constants used by the size-line parser.
// ============================================================================
`default_nettype none

package chbd_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 32;
    localparam int HEX_BITS = 4;

    // Command codes of an input beat.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Characters the parser looks at.
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_LINE  = 3'd1,
        PH_OVF   = 3'd2,
        PH_DATA  = 3'd3,
        PH_DCR   = 3'd4,
        PH_DLF   = 3'd5,
        PH_DONE  = 3'd6
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_CUT_LINE   = 3'd1,
        ST_EMPTY_LINE = 3'd2,
        ST_NO_DIGITS  = 3'd3,
        ST_CUT_DATA   = 3'd4,
        ST_NO_CRLF    = 3'd5,
        ST_OVERFLOW   = 3'd6
    } t_status;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] data_byte;
    } t_item;

    typedef struct packed {
        logic                is_status;
        logic [BYTE_W-1:0]   payload_byte;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    decoded_length;
    } t_result;

endpackage

`default_nettype wire

/* rtl/chbd_if.sv */
// ============================================================================
// chbd_if: valid/ready channels of the chunked body decoder
// The input channel carries body bytes and the end mark, the output channel
// carries decoded payload bytes and the final status beat.
// ============================================================================
`default_nettype none

interface chbd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [chbd_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface chbd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          is_status;
    logic [chbd_pkg::BYTE_W-1:0]   payload_byte;
    logic [chbd_pkg::STATUS_W-1:0] status;
    logic [chbd_pkg::LEN_W-1:0]    decoded_length;

    modport source (output valid, output is_status, output payload_byte,
                    output status, output decoded_length, input ready);
    modport sink   (input valid, input is_status, input payload_byte,
                    input status, input decoded_length, output ready);
endinterface

`default_nettype wire

/* rtl/http_chunked_body_decoder_top.sv */
// ============================================================================
// http_chunked_body_decoder_top: HTTP/1.1 chunked body decoder
// Feed the raw message body one byte per input beat (command 0), then one
// end beat (command 1). The output channel carries each decoded payload
// byte (is_status 0) and, for the end beat, one status beat (is_status 1)
// with the outcome code and the saturating count of payload bytes.
// On a nonzero status the consumer drops the payload beats already taken.
// Timing: a beat accepted on i_in is held in the input register, and its
// result, if any, is loaded into the output register when the parser stage
// consumes the beat. One beat per cycle is sustained while o_out.ready is
// high; the single parser stage that updates the chunk state sets the rate.
// Reset (synchronous, active low) empties both registers and puts the
// parser at the start of a size line with no error and a zero count. After
// every end beat the parser returns to that state by itself.
// When the receiver holds o_out.ready low with a beat waiting, the parser
// stage stops and i_in.ready falls once the input register is also full;
// nothing is lost or repeated.
// ============================================================================
`default_nettype none

module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS  = 32,
    parameter int COUNT_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    chbd_in_if.sink     i_in,
    chbd_out_if.source  o_out
);

    logic              w_in_valid;
    chbd_pkg::t_item   w_item;
    logic              w_can_load;
    logic              w_fire;
    logic              w_res_valid;
    chbd_pkg::t_result w_res;

    // The parser consumes the held beat whenever the result register can load.
    assign w_fire = w_in_valid && w_can_load;

    chbd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_can_load),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    chbd_core #(
        .SIZE_BITS  (SIZE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    chbd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid && w_fire),
        .i_res       (w_res),
        .o_can_load  (w_can_load),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* rtl/chbd_in_reg.sv */
// ============================================================================
// chbd_in_reg: input register of the chunked body decoder
// Captures one beat from the input channel and holds it until the parser
// stage advances.
// ============================================================================
`default_nettype none

module chbd_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    chbd_in_if.sink              i_in,
    input  wire logic            i_advance,
    output logic                 o_valid,
    output chbd_pkg::t_item      o_item
);

    logic            r_valid;
    chbd_pkg::t_item r_item;

    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.command   <= i_in.command;
            r_item.data_byte <= i_in.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* rtl/chbd_core.sv */
// ============================================================================
// chbd_core: chunk parser state of the chunked body decoder
// Advances the parse state by one registered beat per cycle while i_fire
// is high and forms the result beat (payload byte or final status) it causes.
// ============================================================================
`default_nettype none

module chbd_core #(
    parameter int SIZE_BITS,
    parameter int COUNT_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire chbd_pkg::t_item  i_item,
    output logic                  o_res_valid,
    output chbd_pkg::t_result     o_res
);

    // Returns {is_hex, value}.
    function automatic logic [chbd_pkg::HEX_BITS:0] hex_val(
        input logic [chbd_pkg::BYTE_W-1:0] c
    );
        logic [chbd_pkg::HEX_BITS:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic logic is_blank(input logic [chbd_pkg::BYTE_W-1:0] c);
        return (c == chbd_pkg::CH_SPACE) || (c >= chbd_pkg::CH_TAB && c <= chbd_pkg::CH_CR);
    endfunction

    chbd_pkg::t_phase        r_phase, n_phase;
    logic                    r_cr_pending, n_cr_pending;
    logic                    r_digit_seen, n_digit_seen;
    logic                    r_digits_closed, n_digits_closed;
    logic [SIZE_BITS-1:0]    r_chunk, n_chunk;
    chbd_pkg::t_status       r_error, n_error;
    logic [COUNT_BITS-1:0]   r_byte_total, n_byte_total;

    logic [COUNT_BITS+chbd_pkg::LEN_W-1:0] w_total_ext;
    assign w_total_ext = {{chbd_pkg::LEN_W{1'b0}}, r_byte_total};

    always_comb begin
        logic [chbd_pkg::BYTE_W-1:0]  b;
        logic [chbd_pkg::HEX_BITS:0]  hx;
        chbd_pkg::t_phase             p1;
        logic                         dc1;
        chbd_pkg::t_status            st;

        b   = i_item.data_byte;
        hx  = hex_val(b);
        p1  = r_phase;
        dc1 = r_digits_closed;
        st  = r_error;

        n_phase         = r_phase;
        n_cr_pending    = r_cr_pending;
        n_digit_seen    = r_digit_seen;
        n_digits_closed = r_digits_closed;
        n_chunk         = r_chunk;
        n_error         = r_error;
        n_byte_total    = r_byte_total;
        o_res_valid     = 1'b0;
        o_res           = '0;

        if (!i_fire) begin
            // Nothing to do this cycle.
        end else if (i_item.command == chbd_pkg::CMD_END) begin
            if (r_error == chbd_pkg::ST_OK) begin
                unique case (r_phase) inside
                    chbd_pkg::PH_START:
                        st = r_cr_pending ? chbd_pkg::ST_CUT_LINE : chbd_pkg::ST_OK;
                    chbd_pkg::PH_LINE, chbd_pkg::PH_OVF:
                        st = chbd_pkg::ST_CUT_LINE;
                    chbd_pkg::PH_DATA:
                        st = chbd_pkg::ST_CUT_DATA;
                    chbd_pkg::PH_DCR, chbd_pkg::PH_DLF:
                        st = chbd_pkg::ST_NO_CRLF;
                    default:
                        st = chbd_pkg::ST_OK;
                endcase
            end
            o_res_valid          = 1'b1;
            o_res.is_status      = 1'b1;
            o_res.status         = st;
            o_res.decoded_length = w_total_ext[chbd_pkg::LEN_W-1:0];
            // Back to the reset state for the next body.
            n_phase         = chbd_pkg::PH_START;
            n_cr_pending    = 1'b0;
            n_digit_seen    = 1'b0;
            n_digits_closed = 1'b0;
            n_chunk         = '0;
            n_error         = chbd_pkg::ST_OK;
            n_byte_total    = '0;
        end else if (r_error == chbd_pkg::ST_OK) begin
            unique case (r_phase) inside
                chbd_pkg::PH_START, chbd_pkg::PH_LINE, chbd_pkg::PH_OVF: begin
                    if (r_cr_pending && b == chbd_pkg::CH_LF) begin
                        // CR LF closes the size line.
                        if (r_phase == chbd_pkg::PH_START) begin
                            n_error = chbd_pkg::ST_EMPTY_LINE;
                        end else if (r_phase == chbd_pkg::PH_OVF) begin
                            n_error = chbd_pkg::ST_OVERFLOW;
                        end else if (!r_digit_seen) begin
                            n_error = chbd_pkg::ST_NO_DIGITS;
                        end else if (r_chunk == '0) begin
                            n_phase = chbd_pkg::PH_DONE;
                        end else begin
                            n_phase = chbd_pkg::PH_DATA;
                        end
                        n_cr_pending    = 1'b0;
                        n_digit_seen    = 1'b0;
                        n_digits_closed = 1'b0;
                    end else begin
                        // A pending CR not followed by LF counts as a blank line byte.
                        if (r_cr_pending) begin
                            if (r_phase == chbd_pkg::PH_START) begin
                                p1 = chbd_pkg::PH_LINE;
                            end
                            if (p1 != chbd_pkg::PH_OVF) begin
                                dc1 = r_digits_closed | r_digit_seen;
                            end
                        end
                        n_phase         = p1;
                        n_digits_closed = dc1;
                        if (b == chbd_pkg::CH_CR) begin
                            n_cr_pending = 1'b1;
                        end else begin
                            n_cr_pending = 1'b0;
                            if (p1 == chbd_pkg::PH_START) begin
                                n_phase = chbd_pkg::PH_LINE;
                            end
                            if (n_phase != chbd_pkg::PH_OVF && !dc1) begin
                                if (hx[chbd_pkg::HEX_BITS]) begin
                                    if (r_chunk[SIZE_BITS-1 -: chbd_pkg::HEX_BITS] != '0) begin
                                        n_phase = chbd_pkg::PH_OVF;
                                    end else begin
                                        n_chunk = {r_chunk[SIZE_BITS-chbd_pkg::HEX_BITS-1:0],
                                                   hx[chbd_pkg::HEX_BITS-1:0]};
                                        n_digit_seen = 1'b1;
                                    end
                                end else if (!(is_blank(b) && !r_digit_seen)) begin
                                    n_digits_closed = 1'b1;
                                end
                            end
                        end
                    end
                end
                chbd_pkg::PH_DATA: begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = b;
                    if (r_byte_total != '1) begin
                        n_byte_total = r_byte_total + 1'b1;
                    end
                    n_chunk = r_chunk - 1'b1;
                    if (r_chunk == SIZE_BITS'(1)) begin
                        n_phase = chbd_pkg::PH_DCR;
                    end
                end
                chbd_pkg::PH_DCR: begin
                    if (b == chbd_pkg::CH_CR) begin
                        n_phase = chbd_pkg::PH_DLF;
                    end else begin
                        n_error = chbd_pkg::ST_NO_CRLF;
                    end
                end
                chbd_pkg::PH_DLF: begin
                    if (b == chbd_pkg::CH_LF) begin
                        n_phase = chbd_pkg::PH_START;
                    end else begin
                        n_error = chbd_pkg::ST_NO_CRLF;
                    end
                end
                default: begin
                    // After the last chunk every byte is ignored.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= chbd_pkg::PH_START;
            r_cr_pending    <= 1'b0;
            r_digit_seen    <= 1'b0;
            r_digits_closed <= 1'b0;
            r_chunk         <= '0;
            r_error         <= chbd_pkg::ST_OK;
            r_byte_total    <= '0;
        end else begin
            r_phase         <= n_phase;
            r_cr_pending    <= n_cr_pending;
            r_digit_seen    <= n_digit_seen;
            r_digits_closed <= n_digits_closed;
            r_chunk         <= n_chunk;
            r_error         <= n_error;
            r_byte_total    <= n_byte_total;
        end
    end

endmodule

`default_nettype wire

/* rtl/chbd_out_reg.sv */
// ============================================================================
// chbd_out_reg: result register of the chunked body decoder
// Holds one result beat for the output channel and tells the parser stage
// when it may advance.
// ============================================================================
`default_nettype none

module chbd_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_res_valid,
    input  wire chbd_pkg::t_result  i_res,
    output logic                    o_can_load,
    chbd_out_if.source              o_out
);

    logic              r_valid;
    chbd_pkg::t_result r_res;

    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.is_status      = r_res.is_status;
    assign o_out.payload_byte   = r_res.payload_byte;
    assign o_out.status         = r_res.status;
    assign o_out.decoded_length = r_res.decoded_length;

endmodule

`default_nettype wire
